FILE: hw/rtl/lirs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared types and constants for the linear interpolation resampler: rates,
// datapath widths, the constant divider reciprocal and the word structs.
// ----------------------------------------------------------------------------
package lirs_pkg;

   // Sample rates in frames per second
   localparam int IN_RATE  = 32000;
   localparam int OUT_RATE = 48000;

   // Output frames kept per input word; further positions only advance phase
   localparam int MAX_OUT = 2;
   localparam int CNT_W   = $clog2(MAX_OUT + 1);

   // Widths
   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int PHASE_W  = 17;                 // stored phase accumulator
   localparam int ACC_W    = PHASE_W + 1;        // working phase, holds phase + IN_RATE
   localparam int POS_W    = $clog2(OUT_RATE);   // a position below OUT_RATE
   localparam int MAG_W    = SAMPLE_W + POS_W;   // |diff| * position

   // Division by OUT_RATE: drop the power-of-two factor with a shift, then
   // multiply by a rounded-up reciprocal of the odd part (exact for Y_W bits)
   localparam int DIV_SHIFT = 7;
   localparam int DIV_ODD   = OUT_RATE >> DIV_SHIFT;
   localparam int Y_W       = MAG_W - DIV_SHIFT;
   localparam int DIV_K     = Y_W + $clog2(DIV_ODD);
   localparam int RECIP_W   = DIV_K - $clog2(DIV_ODD) + 1;
   localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(
      ((64'd1 << DIV_K) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));
   localparam int QF_W = Y_W + RECIP_W;

   // Input word
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] in_left;
      logic signed [SAMPLE_W-1:0] in_right;
   } req_type;

   // Result word
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
      logic                       run_last;
   } rsp_type;

   // One interpolation job from the sequencer to the datapath
   typedef struct packed {
      logic [SAMPLE_W-1:0] prev_left;
      logic [SAMPLE_W-1:0] prev_right;
      logic [SAMPLE_W-1:0] cur_left;
      logic [SAMPLE_W-1:0] cur_right;
      logic [POS_W-1:0]    position;
      logic                last;
   } job_type;

endpackage

FILE: hw/rtl/lirs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_fifo
// Two-entry input queue. Takes request words and holds them until the
// sequencer has finished with the word ahead.
// ----------------------------------------------------------------------------
module lirs_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lirs_pkg::req_type req_data,
   output logic             q_valid,
   output lirs_pkg::req_type q_data,
   input  logic             q_pop
);

   lirs_pkg::req_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = entry_ff[rd_ptr_ff];

   // Store incoming words
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

   // Pop only a word that is there
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("lirs_fifo: pop from empty queue");

endmodule

FILE: hw/rtl/lirs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_seq
// Phase sequencer. Walks the output positions in the current input frame, one
// per cycle while jobs are taken, issues interpolation jobs, retires the word.
// ----------------------------------------------------------------------------
module lirs_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lirs_pkg::req_type q_data,
   output logic              q_pop,
   output logic              job_valid,
   input  logic              job_ready,
   output lirs_pkg::job_type job
);

   logic [lirs_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [lirs_pkg::SAMPLE_W-1:0] prev_left_ff, prev_left_in;
   logic [lirs_pkg::SAMPLE_W-1:0] prev_right_ff, prev_right_in;
   logic [lirs_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   logic [lirs_pkg::ACC_W-1:0] phase_cur;
   logic [lirs_pkg::ACC_W-1:0] phase_next;
   logic [lirs_pkg::ACC_W-1:0] phase_end;
   logic                       in_range;
   logic                       ends;
   logic                       emit;
   logic                       step;

   // Classify the current position
   always_comb begin
      phase_cur  = {1'b0, phase_ff};
      in_range   = phase_cur < lirs_pkg::ACC_W'(lirs_pkg::OUT_RATE);
      phase_next = phase_cur + lirs_pkg::ACC_W'(lirs_pkg::IN_RATE);
      ends       = !in_range || (phase_next >= lirs_pkg::ACC_W'(lirs_pkg::OUT_RATE));
      phase_end  = (in_range ? phase_next : phase_cur) - lirs_pkg::ACC_W'(lirs_pkg::OUT_RATE);
      emit       = in_range && (cnt_ff < lirs_pkg::CNT_W'(lirs_pkg::MAX_OUT));
      job_valid  = q_valid && emit;
      step       = q_valid && (!emit || job_ready);
      q_pop      = step && ends;
   end

   // Build the job
   always_comb begin
      job.prev_left  = prev_left_ff;
      job.prev_right = prev_right_ff;
      job.cur_left   = q_data.in_left;
      job.cur_right  = q_data.in_right;
      job.position   = phase_ff[lirs_pkg::POS_W-1:0];
      job.last       = ends || (cnt_ff == lirs_pkg::CNT_W'(lirs_pkg::MAX_OUT - 1));
   end

   // Next state: advance within the frame, or retire the word
   always_comb begin
      phase_in      = phase_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      cnt_in        = cnt_ff;
      if (step) begin
         if (ends) begin
            phase_in      = phase_end[lirs_pkg::PHASE_W-1:0];
            prev_left_in  = q_data.in_left;
            prev_right_in = q_data.in_right;
            cnt_in        = '0;
         end else begin
            phase_in = phase_next[lirs_pkg::PHASE_W-1:0];
            if (emit) begin
               cnt_in = cnt_ff + lirs_pkg::CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         cnt_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Emitted count never passes the limit
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= lirs_pkg::CNT_W'(lirs_pkg::MAX_OUT))
      else $error("lirs_seq: output count out of range");

   // Retiring a word restarts the count and leaves a phase below one input step
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (cnt_ff == '0) && (phase_ff < lirs_pkg::PHASE_W'(lirs_pkg::IN_RATE)))
      else $error("lirs_seq: bad state after retiring a word");

   // A job only issues for a position inside the frame
   assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (phase_ff < lirs_pkg::PHASE_W'(lirs_pkg::OUT_RATE)))
      else $error("lirs_seq: job issued outside the frame");

endmodule

FILE: hw/rtl/lirs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_dp
// Interpolation pipeline, three stages: magnitude product, division by the
// output rate through a reciprocal multiply, then sign and add to the
// previous sample. The last stage is the result register.
// ----------------------------------------------------------------------------
module lirs_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  lirs_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lirs_pkg::rsp_type rsp_data
);

   // Stage valids
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   // Stage 1 payload
   logic [lirs_pkg::MAG_W-1:0]    s1_mag_l_ff, s1_mag_r_ff;
   logic                          s1_neg_l_ff, s1_neg_r_ff;
   logic [lirs_pkg::SAMPLE_W-1:0] s1_prev_l_ff, s1_prev_r_ff;
   logic                          s1_last_ff;

   // Stage 2 payload
   logic [lirs_pkg::SAMPLE_W-1:0] s2_q_l_ff, s2_q_r_ff;
   logic                          s2_neg_l_ff, s2_neg_r_ff;
   logic [lirs_pkg::SAMPLE_W-1:0] s2_prev_l_ff, s2_prev_r_ff;
   logic                          s2_last_ff;

   // Stage 3 payload
   lirs_pkg::rsp_type s3_data_ff;

   // Combinational values
   logic [lirs_pkg::DIFF_W-1:0]   diff_l, diff_r;
   logic [lirs_pkg::DIFF_W-1:0]   absd_l, absd_r;
   logic [lirs_pkg::MAG_W-1:0]    mag_l, mag_r;
   logic [lirs_pkg::QF_W-1:0]     qf_l, qf_r;
   logic [lirs_pkg::SAMPLE_W-1:0] res_l, res_r;

   // Stall chain from the result side
   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign job_ready = s1_ready;

   // Stage 1: |cur - prev| * position
   always_comb begin
      diff_l = {job.cur_left[lirs_pkg::SAMPLE_W-1], job.cur_left}
             - {job.prev_left[lirs_pkg::SAMPLE_W-1], job.prev_left};
      diff_r = {job.cur_right[lirs_pkg::SAMPLE_W-1], job.cur_right}
             - {job.prev_right[lirs_pkg::SAMPLE_W-1], job.prev_right};
      absd_l = diff_l[lirs_pkg::DIFF_W-1] ? (~diff_l + lirs_pkg::DIFF_W'(1)) : diff_l;
      absd_r = diff_r[lirs_pkg::DIFF_W-1] ? (~diff_r + lirs_pkg::DIFF_W'(1)) : diff_r;
      mag_l  = lirs_pkg::MAG_W'(absd_l[lirs_pkg::SAMPLE_W-1:0])
             * lirs_pkg::MAG_W'(job.position);
      mag_r  = lirs_pkg::MAG_W'(absd_r[lirs_pkg::SAMPLE_W-1:0])
             * lirs_pkg::MAG_W'(job.position);
   end

   always_ff @(posedge clock) begin
      if (job_valid && s1_ready) begin
         s1_mag_l_ff  <= mag_l;
         s1_mag_r_ff  <= mag_r;
         s1_neg_l_ff  <= diff_l[lirs_pkg::DIFF_W-1];
         s1_neg_r_ff  <= diff_r[lirs_pkg::DIFF_W-1];
         s1_prev_l_ff <= job.prev_left;
         s1_prev_r_ff <= job.prev_right;
         s1_last_ff   <= job.last;
      end
   end

   // Stage 2: floor(mag / OUT_RATE) by shift and reciprocal multiply
   always_comb begin
      qf_l = lirs_pkg::QF_W'(s1_mag_l_ff[lirs_pkg::MAG_W-1:lirs_pkg::DIV_SHIFT])
           * lirs_pkg::QF_W'(lirs_pkg::DIV_RECIP);
      qf_r = lirs_pkg::QF_W'(s1_mag_r_ff[lirs_pkg::MAG_W-1:lirs_pkg::DIV_SHIFT])
           * lirs_pkg::QF_W'(lirs_pkg::DIV_RECIP);
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_q_l_ff    <= qf_l[lirs_pkg::DIV_K +: lirs_pkg::SAMPLE_W];
         s2_q_r_ff    <= qf_r[lirs_pkg::DIV_K +: lirs_pkg::SAMPLE_W];
         s2_neg_l_ff  <= s1_neg_l_ff;
         s2_neg_r_ff  <= s1_neg_r_ff;
         s2_prev_l_ff <= s1_prev_l_ff;
         s2_prev_r_ff <= s1_prev_r_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // Stage 3: apply sign toward zero and add to the previous sample
   always_comb begin
      res_l = s2_neg_l_ff ? (s2_prev_l_ff - s2_q_l_ff) : (s2_prev_l_ff + s2_q_l_ff);
      res_r = s2_neg_r_ff ? (s2_prev_r_ff - s2_q_r_ff) : (s2_prev_r_ff + s2_q_r_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_ready) begin
         s3_data_ff.out_left  <= res_l;
         s3_data_ff.out_right <= res_r;
         s3_data_ff.run_last  <= s2_last_ff;
      end
   end

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= job_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_data_ff;

   // A stalled result stage must not lose a word coming up behind it
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !rsp_ready && s2_valid_ff) |=> s2_valid_ff)
      else $error("lirs_dp: word dropped behind a stalled result");

endmodule

FILE: hw/rtl/linear_interp_resampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_top
// Linear interpolation sample rate converter for signed 16-bit stereo.
// ----------------------------------------------------------------------------
// Each input word is one stereo frame at IN_RATE; for every output position
// between the previous frame and this one the block returns one interpolated
// frame (at most two per input word, run_last set on the final one). The
// sequencer steps one output position per cycle while the pipeline takes
// its jobs, and an input word yields one or two frames at 32 kHz to 48 kHz.
// Results pass through a product, reciprocal-divide and add pipeline whose
// last stage is the result register. A two-word queue sits in front, so
// req_ready does not depend on rsp_ready. Reset clears the phase and the
// previous frame to zero.
// ----------------------------------------------------------------------------
module linear_interp_resampler_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lirs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lirs_pkg::rsp_type rsp_data
);

   logic              q_valid;
   lirs_pkg::req_type q_data;
   logic              q_pop;
   logic              job_valid;
   logic              job_ready;
   lirs_pkg::job_type job;

   // Front: input queue
   lirs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   // Back: phase sequencer
   lirs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   // Back: interpolation pipeline
   lirs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
